>>> hw/rtl/tsvf_pkg.sv
// Package for the trapezoidal state-variable filter: default sizes, register map,
// control word type and the microprogram that drives the datapath.
// No dependencies; every other file of the block imports it.
`default_nettype none

package tsvf_pkg;

    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF = 22;
    localparam int STATE_BITS_DEF     = 32;

    // Damping reset of about 1.414 in a format with 22 fractional bits.
    localparam int          K_RESET_FRAC = 22;
    localparam logic [63:0] K_RESET_RAW  = 64'd5931642;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_A1 = 2'd0;
    localparam logic [1:0] REG_A2 = 2'd1;
    localparam logic [1:0] REG_A3 = 2'd2;
    localparam logic [1:0] REG_K  = 2'd3;

    localparam logic [1:0] COND_NONE     = 2'd0;
    localparam logic [1:0] COND_WAIT_IN  = 2'd1;
    localparam logic [1:0] COND_WAIT_OUT = 2'd2;

    localparam logic [1:0] COEF_A1 = 2'd0;
    localparam logic [1:0] COEF_A2 = 2'd1;
    localparam logic [1:0] COEF_A3 = 2'd2;
    localparam logic [1:0] COEF_K  = 2'd3;

    localparam logic [1:0] OPND_IC1 = 2'd0;
    localparam logic [1:0] OPND_V3  = 2'd1;
    localparam logic [1:0] OPND_V1  = 2'd2;

    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;

    localparam int STEP_W = 3;

    localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_V3    = 3'd1;
    localparam logic [STEP_W-1:0] STEP_MUL   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_ACC1  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_V1    = 3'd4;
    localparam logic [STEP_W-1:0] STEP_ACC2  = 3'd5;
    localparam logic [STEP_W-1:0] STEP_V2    = 3'd6;
    localparam logic [STEP_W-1:0] STEP_FIN   = 3'd7;

    typedef struct packed {
        logic [1:0] cond;
        logic       jump;
        logic [1:0] coef_sel;
        logic [1:0] opnd_sel;
        logic [1:0] acc_op;
        logic       wr_v3;
        logic       wr_v1;
        logic       wr_v2;
        logic       wr_fin;
    } ctrl_t;

    // The product selected in one step is ready in the product register in the next.
    function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
        ctrl_t w;
        begin
            w = '0;
            case (step)
                STEP_IDLE:
                begin
                    w.cond     = COND_WAIT_IN;
                    w.coef_sel = COEF_A1;
                    w.opnd_sel = OPND_IC1;
                end
                STEP_V3:
                begin
                    w.wr_v3    = 1'b1;
                    w.acc_op   = ACC_LOAD;
                    w.coef_sel = COEF_A1;
                    w.opnd_sel = OPND_IC1;
                end
                STEP_MUL:
                begin
                    w.coef_sel = COEF_A2;
                    w.opnd_sel = OPND_V3;
                end
                STEP_ACC1:
                begin
                    w.acc_op   = ACC_ADD;
                    w.coef_sel = COEF_A2;
                    w.opnd_sel = OPND_IC1;
                end
                STEP_V1:
                begin
                    w.wr_v1    = 1'b1;
                    w.acc_op   = ACC_LOAD;
                    w.coef_sel = COEF_A3;
                    w.opnd_sel = OPND_V3;
                end
                STEP_ACC2:
                begin
                    w.acc_op   = ACC_ADD;
                    w.coef_sel = COEF_K;
                    w.opnd_sel = OPND_V1;
                end
                STEP_V2:
                begin
                    w.wr_v2    = 1'b1;
                    w.acc_op   = ACC_LOAD;
                end
                STEP_FIN:
                begin
                    w.wr_fin   = 1'b1;
                    w.cond     = COND_WAIT_OUT;
                    w.jump     = 1'b1;
                end
                default:
                begin
                    w.jump     = 1'b1;
                end
            endcase
            return w;
        end
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tpt_state_variable_filter_top.sv
// Top level of the trapezoidal state-variable filter: stream ports, APB port,
// sequencer, datapath and register file. Depends on tsvf_pkg and all tsvf_ modules.
//
// A sample is accepted in the idle step, and its result enters the output register at the
// end of the last of the eight microprogram steps. The steps route all five coefficient
// products through one shared multiplier and accumulator, and the next sample is taken
// when the step counter returns to its idle step. If the output side still holds the
// previous result, the last step waits until that beat is taken. Outputs and states
// saturate and the clipped flag reports it. Coefficients are to be written over APB only
// while the filter idles; the user is bound by this and the block itself does not enforce it.
`default_nettype none

module tpt_state_variable_filter_top #(
    parameter int SAMPLE_BITS    = tsvf_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = tsvf_pkg::COEF_FRAC_BITS_DEF,
    parameter int STATE_BITS     = tsvf_pkg::STATE_BITS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // sample_in
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // lowpass_out, bandpass_out, highpass_out
    output logic      [((3*SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata,
    // clipped
    output logic                                        m_axis_tuser,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [tsvf_pkg::APB_ADDR_W-1:0]        paddr,
    input  wire logic [tsvf_pkg::APB_DATA_W-1:0]        pwdata,
    output logic      [tsvf_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                        pready
);
    import tsvf_pkg::*;

    localparam int OUT_W = ((3 * SAMPLE_BITS + 7) / 8) * 8;

    ctrl_t                     ctrl;
    logic                      step_go;
    logic                      in_fire;
    logic                      out_busy;
    logic [COEF_FRAC_BITS:0]   coef_a1;
    logic [COEF_FRAC_BITS:0]   coef_a2;
    logic [COEF_FRAC_BITS:0]   coef_a3;
    logic [COEF_FRAC_BITS+1:0] damping_k;
    logic [SAMPLE_BITS-1:0]    lowpass_out;
    logic [SAMPLE_BITS-1:0]    bandpass_out;
    logic [SAMPLE_BITS-1:0]    highpass_out;

    assign in_fire = s_axis_tvalid & s_axis_tready;

    tsvf_cfg_regs #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .coef_a1   (coef_a1),
        .coef_a2   (coef_a2),
        .coef_a3   (coef_a3),
        .damping_k (damping_k)
    );

    tsvf_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_busy (out_busy),
        .ctrl     (ctrl),
        .step_go  (step_go)
    );

    tsvf_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .STATE_BITS     (STATE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .step_go      (step_go),
        .in_fire      (in_fire),
        .sample_in    (s_axis_tdata[SAMPLE_BITS-1:0]),
        .coef_a1      (coef_a1),
        .coef_a2      (coef_a2),
        .coef_a3      (coef_a3),
        .damping_k    (damping_k),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_busy     (out_busy),
        .lowpass_out  (lowpass_out),
        .bandpass_out (bandpass_out),
        .highpass_out (highpass_out),
        .clipped      (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_W'({highpass_out, bandpass_out, lowpass_out});

endmodule

`default_nettype wire

>>> hw/rtl/tsvf_cfg_regs.sv
// APB register file holding the filter coefficients a1, a2, a3 and the damping k.
// Depends on tsvf_pkg for the register map and reset values.
`default_nettype none

module tsvf_cfg_regs #(
    parameter int COEF_FRAC_BITS = tsvf_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tsvf_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [tsvf_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [tsvf_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    output logic      [COEF_FRAC_BITS:0]         coef_a1,
    output logic      [COEF_FRAC_BITS:0]         coef_a2,
    output logic      [COEF_FRAC_BITS:0]         coef_a3,
    output logic      [COEF_FRAC_BITS+1:0]       damping_k
);
    import tsvf_pkg::*;

    localparam int F = COEF_FRAC_BITS;
    localparam logic [63:0] K_RST_L = (F >= K_RESET_FRAC) ?
        (K_RESET_RAW << (F - K_RESET_FRAC)) : (K_RESET_RAW >> (K_RESET_FRAC - F));
    localparam logic [F+1:0] K_RESET  = K_RST_L[F+1:0];
    localparam logic [F:0]   A1_RESET = {1'b1, {F{1'b0}}};

    logic [F:0]   a1_reg;
    logic [F:0]   a2_reg;
    logic [F:0]   a3_reg;
    logic [F+1:0] k_reg;
    logic [1:0]   reg_idx;
    logic         wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_reg <= A1_RESET;
            a2_reg <= '0;
            a3_reg <= '0;
            k_reg  <= K_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_A1:  a1_reg <= pwdata[F:0];
                REG_A2:  a2_reg <= pwdata[F:0];
                REG_A3:  a3_reg <= pwdata[F:0];
                REG_K:   k_reg  <= pwdata[F+1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_A1:  prdata = APB_DATA_W'(a1_reg);
            REG_A2:  prdata = APB_DATA_W'(a2_reg);
            REG_A3:  prdata = APB_DATA_W'(a3_reg);
            REG_K:   prdata = APB_DATA_W'(k_reg);
            default: prdata = '0;
        endcase
    end

    assign coef_a1   = a1_reg;
    assign coef_a2   = a2_reg;
    assign coef_a3   = a3_reg;
    assign damping_k = k_reg;

endmodule

`default_nettype wire

>>> hw/rtl/tsvf_sequencer.sv
// Step counter and microprogram lookup; issues one control word per cycle.
// Depends on tsvf_pkg for the control word type and the program table.
`default_nettype none

module tsvf_sequencer (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic            out_busy,
    output tsvf_pkg::ctrl_t      ctrl,
    output logic                 step_go
);
    import tsvf_pkg::*;

    logic [STEP_W-1:0] pc_reg;
    logic [STEP_W-1:0] pc_next;

    assign ctrl     = ucode_rom(pc_reg);
    assign in_ready = (ctrl.cond == COND_WAIT_IN);

    always_comb
    begin
        case (ctrl.cond)
            COND_WAIT_IN:  step_go = in_valid;
            COND_WAIT_OUT: step_go = ~out_busy;
            default:       step_go = 1'b1;
        endcase
    end

    always_comb
    begin
        if (!step_go)
            pc_next = pc_reg;
        else if (ctrl.jump)
            pc_next = STEP_IDLE;
        else
            pc_next = pc_reg + STEP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= STEP_IDLE;
        else
            pc_reg <= pc_next;
    end

`ifndef SYNTHESIS
    a_ready_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (pc_reg == STEP_IDLE))
        else $error("input ready outside the idle step");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second sample taken while one is in progress");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.cond == COND_WAIT_OUT && out_busy) |=> (pc_reg == STEP_FIN))
        else $error("final step left while the output register is full");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/tsvf_datapath.sv
// Filter datapath: one shared multiplier, an accumulator, rounding and saturation,
// the two integrator states and the output register. Depends on tsvf_pkg.
`default_nettype none

module tsvf_datapath #(
    parameter int SAMPLE_BITS    = tsvf_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = tsvf_pkg::COEF_FRAC_BITS_DEF,
    parameter int STATE_BITS     = tsvf_pkg::STATE_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire tsvf_pkg::ctrl_t             ctrl,
    input  wire logic                        step_go,
    input  wire logic                        in_fire,
    input  wire logic [SAMPLE_BITS-1:0]      sample_in,
    input  wire logic [COEF_FRAC_BITS:0]     coef_a1,
    input  wire logic [COEF_FRAC_BITS:0]     coef_a2,
    input  wire logic [COEF_FRAC_BITS:0]     coef_a3,
    input  wire logic [COEF_FRAC_BITS+1:0]   damping_k,
    input  wire logic                        out_ready,
    output logic                             out_valid,
    output logic                             out_busy,
    output logic      [SAMPLE_BITS-1:0]      lowpass_out,
    output logic      [SAMPLE_BITS-1:0]      bandpass_out,
    output logic      [SAMPLE_BITS-1:0]      highpass_out,
    output logic                             clipped
);
    import tsvf_pkg::*;

    localparam int S      = SAMPLE_BITS;
    localparam int F      = COEF_FRAC_BITS;
    localparam int ST     = STATE_BITS;
    localparam int V_W    = ((ST > S) ? ST : S) + 1;
    localparam int A_W    = F + 3;
    localparam int P_W    = A_W + V_W;
    localparam int FULL_W = P_W + 1;
    localparam int ACC_W  = (FULL_W > 64) ? 64 : FULL_W;
    localparam int RND_W  = ACC_W - F;
    localparam int WIDE   = ((RND_W > V_W) ? RND_W : V_W) + 3;

    logic signed [S-1:0]     x_reg;
    logic signed [ST-1:0]    ic1_reg;
    logic signed [ST-1:0]    ic2_reg;
    logic signed [V_W-1:0]   v3_reg;
    logic signed [ST-1:0]    v1_reg;
    logic signed [ST-1:0]    v2_reg;
    logic        [ACC_W-1:0] prod_reg;
    logic        [ACC_W-1:0] acc_reg;
    logic                    clip_reg;
    logic                    out_valid_reg;
    logic        [S-1:0]     lp_reg;
    logic        [S-1:0]     bp_reg;
    logic        [S-1:0]     hp_reg;
    logic                    clipped_reg;

    logic        [F+1:0]      coef_mux;
    logic signed [A_W-1:0]    mul_a;
    logic signed [V_W-1:0]    mul_b;
    logic signed [P_W-1:0]    prod_full;
    logic        [FULL_W-1:0] prod_wide;
    logic        [ACC_W-1:0]  prod_next;
    logic        [ACC_W-1:0]  acc_next;
    logic        [ACC_W-1:0]  acc_rsum;
    logic signed [RND_W-1:0]  rnd;
    logic signed [WIDE-1:0]   rnd_w;
    logic signed [WIDE-1:0]   x_w;
    logic signed [WIDE-1:0]   ic1_w;
    logic signed [WIDE-1:0]   ic2_w;
    logic signed [WIDE-1:0]   v1_w;
    logic signed [WIDE-1:0]   v2_w;
    logic signed [WIDE-1:0]   hp_w;
    logic signed [WIDE-1:0]   nic1_w;
    logic signed [WIDE-1:0]   nic2_w;
    logic        [WIDE:0]     v1_sat;
    logic        [WIDE:0]     v2_sat;
    logic        [WIDE:0]     nic1_sat;
    logic        [WIDE:0]     nic2_sat;
    logic        [WIDE:0]     lp_sat;
    logic        [WIDE:0]     bp_sat;
    logic        [WIDE:0]     hp_sat;
    logic                     fin_go;
    logic                     fin_clip;

    // Returns the clamped value with the clamp flag in the top bit.
    function automatic logic [WIDE:0] sat_w(input logic signed [WIDE-1:0] v, input int w);
        logic signed [WIDE-1:0] hi;
        logic signed [WIDE-1:0] lo;
        logic        [WIDE:0]   r;
        begin
            hi = WIDE'((WIDE'(1) << (w - 1)) - WIDE'(1));
            lo = ~hi;
            if (v > hi)
                r = {1'b1, hi};
            else if (v < lo)
                r = {1'b1, lo};
            else
                r = {1'b0, v};
            return r;
        end
    endfunction

    always_comb
    begin
        case (ctrl.coef_sel)
            COEF_A1: coef_mux = {1'b0, coef_a1};
            COEF_A2: coef_mux = {1'b0, coef_a2};
            COEF_A3: coef_mux = {1'b0, coef_a3};
            COEF_K:  coef_mux = damping_k;
            default: coef_mux = '0;
        endcase
    end

    always_comb
    begin
        case (ctrl.opnd_sel)
            OPND_IC1: mul_b = {{(V_W-ST){ic1_reg[ST-1]}}, ic1_reg};
            OPND_V3:  mul_b = v3_reg;
            OPND_V1:  mul_b = {{(V_W-ST){v1_reg[ST-1]}}, v1_reg};
            default:  mul_b = '0;
        endcase
    end

    assign mul_a     = {1'b0, coef_mux};
    assign prod_full = mul_a * mul_b;
    assign prod_wide = {prod_full[P_W-1], prod_full};
    assign prod_next = prod_wide[ACC_W-1:0];

    always_comb
    begin
        case (ctrl.acc_op)
            ACC_LOAD: acc_next = prod_reg;
            ACC_ADD:  acc_next = acc_reg + prod_reg;
            default:  acc_next = acc_reg;
        endcase
    end

    assign acc_rsum = acc_reg + (ACC_W'(1) << (F - 1));
    assign rnd      = acc_rsum[ACC_W-1:F];

    assign rnd_w  = {{(WIDE-RND_W){rnd[RND_W-1]}}, rnd};
    assign x_w    = {{(WIDE-S){x_reg[S-1]}}, x_reg};
    assign ic1_w  = {{(WIDE-ST){ic1_reg[ST-1]}}, ic1_reg};
    assign ic2_w  = {{(WIDE-ST){ic2_reg[ST-1]}}, ic2_reg};
    assign v1_w   = {{(WIDE-ST){v1_reg[ST-1]}}, v1_reg};
    assign v2_w   = {{(WIDE-ST){v2_reg[ST-1]}}, v2_reg};
    assign hp_w   = x_w - rnd_w - v2_w;
    assign nic1_w = (v1_w <<< 1) - ic1_w;
    assign nic2_w = (v2_w <<< 1) - ic2_w;

    assign v1_sat   = sat_w(rnd_w, ST);
    assign v2_sat   = sat_w(ic2_w + rnd_w, ST);
    assign nic1_sat = sat_w(nic1_w, ST);
    assign nic2_sat = sat_w(nic2_w, ST);
    assign lp_sat   = sat_w(v2_w, S);
    assign bp_sat   = sat_w(v1_w, S);
    assign hp_sat   = sat_w(hp_w, S);

    assign fin_go   = ctrl.wr_fin & step_go;
    assign fin_clip = clip_reg | nic1_sat[WIDE] | nic2_sat[WIDE] | lp_sat[WIDE]
                    | bp_sat[WIDE] | hp_sat[WIDE];

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (in_fire)
            x_reg <= sample_in;
        if (ctrl.wr_v3)
            v3_reg <= {{(V_W-S){x_reg[S-1]}}, x_reg} - {{(V_W-ST){ic2_reg[ST-1]}}, ic2_reg};
        if (ctrl.wr_v1)
            v1_reg <= v1_sat[ST-1:0];
        if (ctrl.wr_v2)
            v2_reg <= v2_sat[ST-1:0];
        if (fin_go)
        begin
            lp_reg      <= lp_sat[S-1:0];
            bp_reg      <= bp_sat[S-1:0];
            hp_reg      <= hp_sat[S-1:0];
            clipped_reg <= fin_clip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ic1_reg       <= '0;
            ic2_reg       <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                clip_reg <= 1'b0;
            else if (ctrl.wr_v1)
                clip_reg <= clip_reg | v1_sat[WIDE];
            else if (ctrl.wr_v2)
                clip_reg <= clip_reg | v2_sat[WIDE];
            if (fin_go)
            begin
                ic1_reg <= nic1_sat[ST-1:0];
                ic2_reg <= nic2_sat[ST-1:0];
            end
            if (fin_go)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_busy     = out_valid_reg & ~out_ready;
    assign lowpass_out  = lp_reg;
    assign bandpass_out = bp_reg;
    assign highpass_out = hp_reg;
    assign clipped      = clipped_reg;

endmodule

`default_nettype wire

>>> test/tpt_state_variable_filter_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for tpt_state_variable_filter_top: streams audio samples, checks
// lowpass, bandpass, highpass and the clip flag against a fixed-point filter predictor.
// Depends on tsvf_pkg and the filter RTL only.

module tpt_state_variable_filter_top_test;

    localparam int SW           = tsvf_pkg::SAMPLE_BITS_DEF;
    localparam int FB           = tsvf_pkg::COEF_FRAC_BITS_DEF;
    localparam int STW          = tsvf_pkg::STATE_BITS_DEF;
    localparam int IN_W         = ((SW + 7) / 8) * 8;
    localparam int OUT_W        = ((3 * SW + 7) / 8) * 8;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE       = 16;
    localparam int PHASE_ITEMS  = 300;
    localparam int PHASES       = 6;

    localparam logic [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};

    typedef struct packed {
        logic [SW-1:0] low;
        logic [SW-1:0] band;
        logic [SW-1:0] high;
        logic          clip;
    } filter_out_t;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  regidx;
        logic [31:0] value;
        bit          known;
        filter_out_t result;
    } stim_row_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    // sample_in
    logic [IN_W-1:0]                   s_axis_tdata = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    // lowpass_out, bandpass_out, highpass_out
    logic [OUT_W-1:0]                  m_axis_tdata;
    // clipped
    logic                              m_axis_tuser;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [tsvf_pkg::APB_ADDR_W-1:0]   paddr = '0;
    logic [tsvf_pkg::APB_DATA_W-1:0]   pwdata = '0;
    logic [tsvf_pkg::APB_DATA_W-1:0]   prdata;
    logic                              pready;

    logic [FB:0]   a1_q = (FB+1)'(1) << FB;
    logic [FB:0]   a2_q = '0;
    logic [FB:0]   a3_q = '0;
    logic [FB+1:0] k_q  = tsvf_pkg::K_RESET_RAW[FB+1:0];
    longint        ic1_q = 0;
    longint        ic2_q = 0;

    filter_out_t   outputs_due[$];
    int            mismatches = 0;
    int            cycles = 0;

    tpt_state_variable_filter_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    function automatic longint clamp(input longint v, input int w, inout bit hit);
        longint top;
        top = (longint'(1) <<< (w - 1)) - 1;
        if (v > top)
        begin
            hit = 1'b1;
            return top;
        end
        if (v < -top - 1)
        begin
            hit = 1'b1;
            return -top - 1;
        end
        return v;
    endfunction

    function automatic longint round_q(input longint acc);
        return (acc + (longint'(1) <<< (FB - 1))) >>> FB;
    endfunction

    function automatic filter_out_t filter_step(input logic [SW-1:0] smp);
        longint      x;
        longint      v1;
        longint      v2;
        longint      v3;
        longint      hp;
        bit          hit;
        filter_out_t r;
        hit = 1'b0;
        x  = longint'($signed(smp));
        v3 = x - ic2_q;
        v1 = clamp(round_q(longint'(a1_q) * ic1_q + longint'(a2_q) * v3), STW, hit);
        v2 = clamp(ic2_q + round_q(longint'(a2_q) * ic1_q + longint'(a3_q) * v3), STW, hit);
        hp = x - round_q(longint'(k_q) * v1) - v2;
        ic1_q = clamp(2 * v1 - ic1_q, STW, hit);
        ic2_q = clamp(2 * v2 - ic2_q, STW, hit);
        r.low  = SW'(clamp(v2, SW, hit));
        r.band = SW'(clamp(v1, SW, hit));
        r.high = SW'(clamp(hp, SW, hit));
        r.clip = hit;
        return r;
    endfunction

    function automatic stim_row_t sample_row(input logic [31:0] value, input bit known,
                                             input int lp, input int bp, input int hp);
        stim_row_t r;
        r.kind        = ROW_SAMPLE;
        r.regidx      = tsvf_pkg::REG_A1;
        r.value       = value;
        r.known       = known;
        r.result.low  = SW'(lp);
        r.result.band = SW'(bp);
        r.result.high = SW'(hp);
        r.result.clip = 1'b0;
        return r;
    endfunction

    function automatic stim_row_t write_row(input logic [1:0] regidx, input logic [31:0] value);
        stim_row_t r;
        r        = sample_row(value, 1'b0, 0, 0, 0);
        r.kind   = ROW_WRITE;
        r.regidx = regidx;
        return r;
    endfunction

    function automatic logic [SW-1:0] random_sample();
        case ($urandom_range(0, 9))
            6: return $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
            7, 8: return SW'(int'($urandom_range(0, 4095)) - 2048);
            default: return SW'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (outputs_due.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] regidx, input logic [31:0] value);
        logic [31:0] stored;
        wait_idle();
        case (regidx)
            tsvf_pkg::REG_A1: a1_q = value[FB:0];
            tsvf_pkg::REG_A2: a2_q = value[FB:0];
            tsvf_pkg::REG_A3: a3_q = value[FB:0];
            tsvf_pkg::REG_K:  k_q  = value[FB+1:0];
            default: ;
        endcase
        stored = (regidx == tsvf_pkg::REG_K) ? 32'(value[FB+1:0]) : 32'(value[FB:0]);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {regidx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== stored)
            report_mismatch("register readback", stored, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_sample(input logic [SW-1:0] smp, input int gap, input bit known,
                               input filter_out_t typed);
        filter_out_t pred;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'(smp);
        do @(posedge clk); while (!s_axis_tready);
        pred = filter_step(smp);
        outputs_due.push_back(known ? typed : pred);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin : cycle_guard
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin : output_stall
        static int mode = 0;
        static int hold = 0;
        static int tick = 0;
        tick++;
        if (tick % 128 == 0)
            mode = $urandom_range(0, 3);
        case (mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= $urandom_range(0, 1);
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:
            begin
                if (hold > 0)
                begin
                    hold--;
                    m_axis_tready <= 1'b0;
                end
                else
                begin
                    m_axis_tready <= 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        hold = $urandom_range(5, 30);
                end
            end
        endcase
    end

    always @(posedge clk)
    begin : output_check
        filter_out_t got;
        filter_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.low  = m_axis_tdata[SW-1:0];
            got.band = m_axis_tdata[2*SW-1:SW];
            got.high = m_axis_tdata[3*SW-1:2*SW];
            got.clip = m_axis_tuser;
            if (outputs_due.size() == 0)
                report_mismatch("unexpected beat, lowpass", 0, $signed(got.low));
            else
            begin
                want = outputs_due.pop_front();
                if (got.low !== want.low)
                    report_mismatch("lowpass", $signed(want.low), $signed(got.low));
                if (got.band !== want.band)
                    report_mismatch("bandpass", $signed(want.band), $signed(got.band));
                if (got.high !== want.high)
                    report_mismatch("highpass", $signed(want.high), $signed(got.high));
                if (got.clip !== want.clip)
                    report_mismatch("clipped", want.clip, got.clip);
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t   directed_rows[$];
        real         scale;
        real         g;
        real         kd;
        real         a1r;
        logic [31:0] v_a1;
        logic [31:0] v_a2;
        logic [31:0] v_a3;
        logic [31:0] v_k;
        int          burst_left;
        int          gap;

        // With the reset coefficients the filter passes the input straight to highpass.
        directed_rows.push_back(sample_row(0, 1'b1, 0, 0, 0));
        directed_rows.push_back(sample_row(8388607, 1'b1, 0, 0, 8388607));
        directed_rows.push_back(sample_row(-8388608, 1'b1, 0, 0, -8388608));
        directed_rows.push_back(sample_row(1, 1'b1, 0, 0, 1));
        directed_rows.push_back(sample_row(-1, 1'b1, 0, 0, -1));
        directed_rows.push_back(sample_row(32'h0055_5555, 1'b1, 0, 0, 5592405));
        directed_rows.push_back(sample_row(32'h00AA_AAAA, 1'b1, 0, 0, -5592406));
        // Unity coefficients and maximum damping drive the outputs into saturation.
        directed_rows.push_back(write_row(tsvf_pkg::REG_A2, 4194304));
        directed_rows.push_back(write_row(tsvf_pkg::REG_A3, 4194304));
        directed_rows.push_back(write_row(tsvf_pkg::REG_K, 32'hFFFF_FFFF));
        directed_rows.push_back(sample_row(8388607, 1'b0, 0, 0, 0));
        directed_rows.push_back(sample_row(8388607, 1'b0, 0, 0, 0));
        directed_rows.push_back(sample_row(-8388608, 1'b0, 0, 0, 0));
        directed_rows.push_back(sample_row(-8388608, 1'b0, 0, 0, 0));
        directed_rows.push_back(sample_row(8388607, 1'b0, 0, 0, 0));
        // Coefficients above one are kept as written, masked to the register width.
        directed_rows.push_back(write_row(tsvf_pkg::REG_A1, 32'hFFFF_FFFF));
        directed_rows.push_back(write_row(tsvf_pkg::REG_A2, 32'hFFFF_FFFF));
        directed_rows.push_back(write_row(tsvf_pkg::REG_A3, 32'hFFFF_FFFF));
        directed_rows.push_back(sample_row(8388607, 1'b0, 0, 0, 0));
        directed_rows.push_back(sample_row(-8388608, 1'b0, 0, 0, 0));
        directed_rows.push_back(sample_row(0, 1'b0, 0, 0, 0));
        directed_rows.push_back(write_row(tsvf_pkg::REG_A1, 0));
        directed_rows.push_back(write_row(tsvf_pkg::REG_A2, 0));
        directed_rows.push_back(write_row(tsvf_pkg::REG_A3, 0));
        directed_rows.push_back(write_row(tsvf_pkg::REG_K, 0));
        directed_rows.push_back(sample_row(8388607, 1'b0, 0, 0, 0));
        directed_rows.push_back(sample_row(0, 1'b0, 0, 0, 0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
                write_reg(directed_rows[i].regidx, directed_rows[i].value);
            else
                send_sample(directed_rows[i].value[SW-1:0], $urandom_range(0, 2),
                            directed_rows[i].known, directed_rows[i].result);
        end

        scale      = 2.0 ** FB;
        burst_left = 1;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                1:
                begin
                    v_a1 = 4194304;
                    v_a2 = 4194304;
                    v_a3 = 4194304;
                    v_k  = 16777215;
                end
                2:
                begin
                    v_a1 = 0;
                    v_a2 = 0;
                    v_a3 = 0;
                    v_k  = 0;
                end
                4:
                begin
                    v_a1 = $urandom_range(0, 4194304);
                    v_a2 = $urandom_range(0, 4194304);
                    v_a3 = $urandom_range(0, 4194304);
                    v_k  = $urandom_range(0, 16777215);
                end
                default:
                begin
                    g    = $urandom_range(10, 4000) / 1000.0;
                    kd   = $urandom_range(50, 3900) / 1000.0;
                    a1r  = 1.0 / (1.0 + g * (g + kd));
                    v_a1 = $rtoi(a1r * scale);
                    v_a2 = $rtoi(g * a1r * scale);
                    v_a3 = $rtoi(g * g * a1r * scale);
                    v_k  = $rtoi(kd * scale);
                end
            endcase
            write_reg(tsvf_pkg::REG_A1, v_a1);
            write_reg(tsvf_pkg::REG_A2, v_a2);
            write_reg(tsvf_pkg::REG_A3, v_a3);
            write_reg(tsvf_pkg::REG_K, v_k);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                burst_left--;
                gap = 0;
                if (burst_left <= 0)
                begin
                    gap        = $urandom_range(1, 12);
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                             : $urandom_range(1, 16);
                end
                if (n == PHASE_ITEMS / 2 && gap == 0)
                    gap = 1;
                send_sample(random_sample(), gap, 1'b0, '0);
                if (n == PHASE_ITEMS / 2)
                    wait_idle();
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
